FILE: design/csrgb_pkg.sv
// ----------------------------------------------------------------------------
// csrgb_pkg
// Shared types and constants of the CSR graph builder.
// ----------------------------------------------------------------------------
`default_nettype none
package csrgb_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned MAX_EDGES_DEF    = 4096;
  localparam int unsigned NV_W             = 11;
  localparam int unsigned VTX_W            = 10;
  localparam int unsigned VAL_W            = 13;
  localparam int unsigned NV_RESET         = 1024;

  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_FIN  = 2'd1;
  localparam logic [1:0] FUNC_RROW = 2'd2;
  localparam logic [1:0] FUNC_RCOL = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_VTX = 2'd2;
  localparam logic [1:0] ST_BAD_RD  = 2'd3;

  localparam logic [2:0] REG_VTX_COUNT = 3'd0;

  typedef struct packed {
    logic [1:0]       func;
    logic [VTX_W-1:0] src_vertex;
    logic [VTX_W-1:0] dst_vertex;
    logic [VAL_W-1:0] read_index;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       status;
  } out_t;

  typedef struct packed {
    logic add;
    logic rd_issue;
    logic rd_out;
    logic clr;
    logic cnt_c;
    logic pfx_a;
    logic pfx_b;
    logic sct_c;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic ec_zero;
    logic e_last;
    logic v_last;
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/csrgb_ctrl.sv
// ----------------------------------------------------------------------------
// csrgb_ctrl
// Sequencer: request decode and the finish phases (clear, count, prefix, scatter).
// ----------------------------------------------------------------------------
`default_nettype none
module csrgb_ctrl
  import csrgb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_func,
  output logic            in_stall,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD    = 11'b00000000010,
    S_CLR   = 11'b00000000100,
    S_CNT_A = 11'b00000001000,
    S_CNT_B = 11'b00000010000,
    S_CNT_C = 11'b00000100000,
    S_PFX_A = 11'b00001000000,
    S_PFX_B = 11'b00010000000,
    S_SCT_A = 11'b00100000000,
    S_SCT_B = 11'b01000000000,
    S_SCT_C = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   fin_r, fin_nxt;
  logic   acc;

  assign in_stall = (state_r != S_IDLE) || fin_r || sts.out_full;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = 1'b0;
    cmd       = '0;
    cmd.done  = fin_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_func)
            FUNC_ADD:  cmd.add = 1'b1;
            FUNC_FIN:  state_nxt = S_CLR;
            default: begin
              cmd.rd_issue = 1'b1;
              state_nxt    = S_RD;
            end
          endcase
        end
      end
      S_RD: begin
        cmd.rd_out = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.v_last) state_nxt = sts.ec_zero ? S_PFX_A : S_CNT_A;
      end
      S_CNT_A: state_nxt = S_CNT_B;
      S_CNT_B: state_nxt = S_CNT_C;
      S_CNT_C: begin
        cmd.cnt_c = 1'b1;
        if (sts.e_last) state_nxt = S_PFX_A;
        else state_nxt = S_CNT_A;
      end
      S_PFX_A: begin
        cmd.pfx_a = 1'b1;
        state_nxt = S_PFX_B;
      end
      S_PFX_B: begin
        cmd.pfx_b = 1'b1;
        if (!sts.v_last) state_nxt = S_PFX_A;
        else if (sts.ec_zero) begin
          state_nxt = S_IDLE;
          fin_nxt   = 1'b1;
        end else state_nxt = S_SCT_A;
      end
      S_SCT_A: state_nxt = S_SCT_B;
      S_SCT_B: state_nxt = S_SCT_C;
      S_SCT_C: begin
        cmd.sct_c = 1'b1;
        if (sts.e_last) begin
          state_nxt = S_IDLE;
          fin_nxt   = 1'b1;
        end else state_nxt = S_SCT_A;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

  a_fin_starts_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_func == FUNC_FIN |=> state_r == S_CLR)
    else $error("finish did not start clear phase");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |=> state_r == S_IDLE && !fin_r)
    else $error("read phase overran");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state not one-hot");

endmodule
`default_nettype wire

FILE: design/csrgb_dp.sv
// ----------------------------------------------------------------------------
// csrgb_dp
// Datapath: edge stores, count/cursor, row offset and column memories, counters,
// result register.
// ----------------------------------------------------------------------------
`default_nettype none
module csrgb_dp
  import csrgb_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = MAX_EDGES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire in_t             in_data,
  input  wire logic [NV_W-1:0] nv_cfg,
  input  wire cmd_t            cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_t                 out_data
);

  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned NW  = $clog2(MAX_VERTICES + 1);

  logic [VTX_W-1:0] esrc_mem [MAX_EDGES];
  logic [VTX_W-1:0] edst_mem [MAX_EDGES];
  logic [EW-1:0]    cnt_mem  [MAX_VERTICES];
  logic [EW-1:0]    row_mem  [MAX_VERTICES+1];
  logic [VTX_W-1:0] col_mem  [MAX_EDGES];

  logic [VTX_W-1:0] esrc_q, edst_q, col_q;
  logic [EW-1:0]    cnt_q, row_q;

  logic [EW-1:0]    ec_r, ec_nxt, e_r, e_nxt, total_r, total_nxt;
  logic [EW-1:0]    sum_r, sum_nxt, placed_r, placed_nxt;
  logic [NW-1:0]    i_r, i_nxt, bv_r, bv_nxt;
  logic [VTX_W-1:0] u_r, dst_r;
  logic             ok_r, built_r, built_nxt, bad_r, isrow_r;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic [31:0]      nv32, idx32, ec_eff32, e32, i32, src32, dst32, q32;
  logic [NW-1:0]    nv;
  logic [EW-1:0]    ec_eff;
  logic             add_bad_vtx, add_full, add_wr;

  always_comb begin
    if (nv_cfg == '0) nv32 = 32'd1;
    else if (32'(nv_cfg) > MAX_VERTICES) nv32 = MAX_VERTICES;
    else nv32 = 32'(nv_cfg);
  end
  assign nv     = nv32[NW-1:0];
  assign idx32  = 32'(in_data.read_index);
  assign src32  = 32'(in_data.src_vertex);
  assign dst32  = 32'(in_data.dst_vertex);
  assign ec_eff = built_r ? '0 : ec_r;
  assign ec_eff32 = 32'(ec_eff);
  assign e32    = 32'(e_r);
  assign i32    = 32'(i_r);
  assign q32    = 32'(esrc_q);

  assign add_bad_vtx = (src32 >= nv32) || (dst32 >= nv32);
  assign add_full    = ec_eff32 >= MAX_EDGES;
  assign add_wr      = cmd.add && !add_bad_vtx && !add_full;

  assign sts.ec_zero  = (ec_r == '0);
  assign sts.e_last   = (e32 + 32'd1 == 32'(ec_r));
  assign sts.v_last   = (i32 + 32'd1 == nv32);
  assign sts.out_full = out_valid_r && out_stall;

  // edge stores
  always_ff @(posedge clk) begin
    if (add_wr) begin
      esrc_mem[ec_eff32[AW-1:0]] <= in_data.src_vertex;
      edst_mem[ec_eff32[AW-1:0]] <= in_data.dst_vertex;
    end
    esrc_q <= esrc_mem[e32[AW-1:0]];
    edst_q <= edst_mem[e32[AW-1:0]];
  end

  // degree counts, later fill cursors
  logic          cnt_we;
  logic [VW-1:0] cnt_wa, cnt_ra;
  logic [EW-1:0] cnt_wd;
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = i32[VW-1:0];
    cnt_wd = '0;
    if (cmd.clr) cnt_we = 1'b1;
    if (cmd.pfx_b) begin
      cnt_we = 1'b1;
      cnt_wd = sum_r;
    end
    if ((cmd.cnt_c || cmd.sct_c) && ok_r) begin
      cnt_we = 1'b1;
      cnt_wa = VW'(u_r);
      cnt_wd = cnt_q + EW'(1);
    end
    cnt_ra = cmd.pfx_a ? i32[VW-1:0] : q32[VW-1:0];
  end
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[cnt_ra];
  end

  // row offsets
  logic [31:0] row_wa32;
  assign row_wa32 = cmd.pfx_b ? i32 + 32'd1 : i32;
  always_ff @(posedge clk) begin
    if (cmd.clr || cmd.pfx_b) row_mem[row_wa32[NW-1:0]] <= cmd.pfx_b ? sum_r + cnt_q : '0;
    row_q <= row_mem[idx32[NW-1:0]];
  end

  // column entries
  logic [31:0] pos32;
  assign pos32 = 32'(cnt_q);
  always_ff @(posedge clk) begin
    if (cmd.sct_c && ok_r) col_mem[pos32[AW-1:0]] <= dst_r;
    col_q <= col_mem[idx32[AW-1:0]];
  end

  always_comb begin
    ec_nxt     = ec_r;
    e_nxt      = e_r;
    i_nxt      = i_r;
    sum_nxt    = sum_r;
    placed_nxt = placed_r;
    total_nxt  = total_r;
    bv_nxt     = bv_r;
    built_nxt  = built_r;
    out_nxt    = out_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    if (cmd.add) begin
      built_nxt     = 1'b0;
      out_valid_nxt = 1'b1;
      if (add_bad_vtx) out_nxt = '{VAL_W'(ec_eff32), ST_BAD_VTX};
      else if (add_full) out_nxt = '{VAL_W'(ec_eff32), ST_FULL};
      else begin
        ec_nxt  = ec_eff + EW'(1);
        out_nxt = '{VAL_W'(ec_eff32 + 32'd1), ST_OK};
      end
      ec_nxt = add_wr ? ec_eff + EW'(1) : ec_eff;
    end
    if (cmd.rd_out) begin
      out_valid_nxt = 1'b1;
      if (bad_r) out_nxt = '{'0, ST_BAD_RD};
      else if (isrow_r) out_nxt = '{VAL_W'(32'(row_q)), ST_OK};
      else out_nxt = '{VAL_W'(32'(col_q)), ST_OK};
    end
    if (cmd.clr) begin
      sum_nxt    = '0;
      placed_nxt = '0;
      e_nxt      = '0;
      i_nxt      = sts.v_last ? '0 : i_r + NW'(1);
    end
    if (cmd.cnt_c || cmd.sct_c) e_nxt = sts.e_last ? '0 : e_r + EW'(1);
    if (cmd.sct_c && ok_r) placed_nxt = placed_r + EW'(1);
    if (cmd.pfx_b) begin
      sum_nxt = sum_r + cnt_q;
      i_nxt   = sts.v_last ? '0 : i_r + NW'(1);
    end
    if (cmd.done) begin
      built_nxt     = 1'b1;
      bv_nxt        = nv;
      total_nxt     = sum_r;
      out_valid_nxt = 1'b1;
      out_nxt       = '{VAL_W'(32'(placed_r)), ST_OK};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_r        <= '0;
      built_r     <= 1'b0;
      bv_r        <= NW'(1);
      out_valid_r <= 1'b0;
      e_r         <= '0;
      i_r         <= '0;
    end else begin
      ec_r        <= ec_nxt;
      built_r     <= built_nxt;
      bv_r        <= bv_nxt;
      out_valid_r <= out_valid_nxt;
      e_r         <= e_nxt;
      i_r         <= i_nxt;
    end
    sum_r    <= sum_nxt;
    placed_r <= placed_nxt;
    total_r  <= total_nxt;
    out_r    <= out_nxt;
    u_r      <= esrc_q;
    dst_r    <= edst_q;
    ok_r     <= q32 < nv32;
    if (cmd.rd_issue) begin
      isrow_r <= (in_data.func == FUNC_RROW);
      bad_r   <= !built_r ||
                 ((in_data.func == FUNC_RROW) ? (idx32 > 32'(bv_r))
                                              : (idx32 >= 32'(total_r)));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_ec_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ec_r) <= MAX_EDGES)
    else $error("edge count beyond store");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.add || cmd.rd_out || cmd.done) |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_done_builds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |=> built_r && out_valid_r)
    else $error("finish did not mark graph built");

endmodule
`default_nettype wire

FILE: design/csr_graph_builder.sv
// ----------------------------------------------------------------------------
// csr_graph_builder
// Edge list to CSR adjacency builder by counting sort.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries requests: add edge, finish,
// read row offset, read column entry. Each request gives one result on
// out_valid/out_stall/out_data. One request is in work at a time.
//   add edge    : result registered at the accept edge.
//   read        : registered memory read, then the result register.
//   finish      : for nv vertices and E stored edges: clear counts, count
//                 degrees, prefix sum, scatter (count and scatter skipped
//                 with no edges), through one-write one-read memories.
// The vertex count register is written through the APB port (paddr[2] = 0);
// the user must write it only while idle, the block does not enforce it.
// Reset clears the edge count, the built flag and the output valid flag; no
// memory clearing pass is needed. While out_stall holds a result, in_stall
// stays high and no new request is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module csr_graph_builder
  import csrgb_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = MAX_EDGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [NV_W-1:0] nv_cfg_r;
  logic            reg_hit;
  cmd_t            cmd;
  sts_t            sts;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_VTX_COUNT[2]);
  assign prdata  = reg_hit ? 32'(nv_cfg_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) nv_cfg_r <= NV_W'(NV_RESET);
    else if (psel && penable && pwrite && reg_hit) nv_cfg_r <= pwdata[NV_W-1:0];
  end

  csrgb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  csrgb_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .nv_cfg    (nv_cfg_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
